[hw/rtl/tgad_pkg.sv]
package tgad_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_IDSKIP = 3'd1,
    PH_PACKET = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_DRAIN  = 3'd4
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_ZERO_DIM  = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // header byte offsets
  localparam logic [4:0] HB_ID_LEN    = 5'd0;
  localparam logic [4:0] HB_TYPE      = 5'd2;
  localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HB_DEPTH     = 5'd16;
  localparam logic [4:0] HB_DESC      = 5'd17;
  localparam logic [4:0] HB_LAST      = 5'd17;

  localparam logic [7:0] RLE_TYPE   = 8'd10;
  localparam logic [7:0] DEPTH_24   = 8'd24;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] COUNT_MASK = 8'h7F;
  localparam int unsigned RUN_BIT   = 7;
  localparam int unsigned TOP_BIT   = 5;
  localparam logic [7:0] OPAQUE     = 8'd255;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] pixel_index;
    logic [7:0]  repeat_count;
    logic [2:0]  status;
    logic        top_origin;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;
  } res_t;

endpackage

[hw/rtl/tgad_res_buf.sv]
// Two-slot result buffer: head slot drives the outputs, second slot catches
// a word produced while the head is stalled.
module tgad_res_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  tgad_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output tgad_pkg::res_t out_data
);

  logic           v0_r, v0_nxt;
  logic           v1_r, v1_nxt;
  tgad_pkg::res_t d0_r, d0_nxt;
  tgad_pkg::res_t d1_r, d1_nxt;
  logic           pop;

  assign pop       = v0_r && out_ready;
  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_data  = d0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      if (v1_r) begin
        d0_nxt = d1_r;
        if (push_valid) begin
          d1_nxt = push_data;
        end else begin
          v1_nxt = 1'b0;
        end
      end else if (push_valid) begin
        d0_nxt = push_data;
      end else begin
        v0_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (v0_r) begin
        d1_nxt = push_data;
        v1_nxt = 1'b1;
      end else begin
        d0_nxt = push_data;
        v0_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// channel  | ports                                    | handshake
// ---------+------------------------------------------+----------------------
// in       | in_data_byte, in_end_of_file             | in_valid / in_ready
// out      | out_red .. out_last (one pixel/status)   | out_valid / out_ready
//
// One file byte per clock while in_ready is high; every byte is decoded
// in the cycle it is taken, and its result is pushed into the result buffer.
// in_ready falls only when both slots of the result buffer hold words.
// Pixel count limit uses a width*height product registered from the width
// and height registers; the header guarantees it is settled before any pixel.
// Synchronous active-low reset; end_of_file also resets the decoder state.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [31:0] out_pixel_index,
  output logic [7:0]  out_repeat_count,
  output logic [2:0]  out_status,
  output logic        out_top_origin,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic        out_last
);

  tgad_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        four_r, four_nxt;
  logic        rle_r, rle_nxt;
  logic        top_r, top_nxt;
  logic [31:0] done_r, done_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [23:0] pix_bytes_r, pix_bytes_nxt;
  logic [1:0]  pix_idx_r, pix_idx_nxt;
  logic [31:0] total_r;

  logic           buf_full;
  logic           in_fire;
  logic           eof;
  logic [7:0]     b;
  logic           hdr_last;
  logic [2:0]     hdr_err;
  logic           pix_end;
  logic [31:0]    remaining;
  logic [7:0]     rep_raw;
  logic [7:0]     rep_clip;
  logic           img_done;
  tgad_pkg::phase_t data_phase;
  logic           res_emit;
  tgad_pkg::res_t res;
  tgad_pkg::res_t out_word;

  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;
  assign eof      = in_end_of_file;
  assign b        = in_data_byte;

  assign hdr_last = (hdr_cnt_r == tgad_pkg::HB_LAST);
  always_comb begin
    if (width_r == 16'd0 || height_r == 16'd0) begin
      hdr_err = tgad_pkg::ST_ZERO_DIM;
    end else if (pix_bytes_r[7:0] != tgad_pkg::DEPTH_24 &&
                 pix_bytes_r[7:0] != tgad_pkg::DEPTH_32) begin
      hdr_err = tgad_pkg::ST_BAD_DEPTH;
    end else begin
      hdr_err = tgad_pkg::ST_PIXEL;
    end
  end
  assign data_phase = rle_r ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;

  assign pix_end   = (pix_idx_r == (four_r ? 2'd3 : 2'd2));
  assign remaining = total_r - done_r;
  assign rep_raw   = (rle_r && pkt_run_r) ? pkt_left_r : 8'd1;
  assign rep_clip  = (remaining[31:8] == 24'd0 && remaining[7:0] < rep_raw) ?
                     remaining[7:0] : rep_raw;
  assign img_done  = ({24'd0, rep_clip} == remaining);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (eof) begin
        phase_nxt = tgad_pkg::PH_HEADER;
      end else begin
        unique case (phase_r)
          tgad_pkg::PH_HEADER: begin
            if (hdr_last) begin
              if (hdr_err != tgad_pkg::ST_PIXEL) begin
                phase_nxt = tgad_pkg::PH_DRAIN;
              end else if (id_left_r != 8'd0) begin
                phase_nxt = tgad_pkg::PH_IDSKIP;
              end else begin
                phase_nxt = data_phase;
              end
            end
          end
          tgad_pkg::PH_IDSKIP: begin
            if (id_left_r == 8'd1) begin
              phase_nxt = data_phase;
            end
          end
          tgad_pkg::PH_PACKET: phase_nxt = tgad_pkg::PH_PIXEL;
          tgad_pkg::PH_PIXEL: begin
            if (pix_end) begin
              if (img_done) begin
                phase_nxt = tgad_pkg::PH_DRAIN;
              end else if (rle_r && (pkt_run_r || pkt_left_r <= 8'd1)) begin
                phase_nxt = tgad_pkg::PH_PACKET;
              end
            end
          end
          default: phase_nxt = tgad_pkg::PH_DRAIN;
        endcase
      end
    end
  end

  // datapath and result word
  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    id_left_nxt   = id_left_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    four_nxt      = four_r;
    rle_nxt       = rle_r;
    top_nxt       = top_r;
    done_nxt      = done_r;
    pkt_left_nxt  = pkt_left_r;
    pkt_run_nxt   = pkt_run_r;
    pix_bytes_nxt = pix_bytes_r;
    pix_idx_nxt   = pix_idx_r;

    res_emit         = 1'b0;
    res.red          = 8'd0;
    res.green        = 8'd0;
    res.blue         = 8'd0;
    res.alpha        = 8'd0;
    res.pixel_index  = done_r;
    res.repeat_count = 8'd0;
    res.status       = tgad_pkg::ST_TRUNCATED;
    res.last         = 1'b1;

    case (phase_r)
      tgad_pkg::PH_HEADER: begin
        unique case (hdr_cnt_r)
          tgad_pkg::HB_ID_LEN:    id_left_nxt = b;
          tgad_pkg::HB_TYPE:      rle_nxt = (b == tgad_pkg::RLE_TYPE);
          tgad_pkg::HB_WIDTH_LO:  width_nxt[7:0] = b;
          tgad_pkg::HB_WIDTH_HI:  width_nxt[15:8] = b;
          tgad_pkg::HB_HEIGHT_LO: height_nxt[7:0] = b;
          tgad_pkg::HB_HEIGHT_HI: height_nxt[15:8] = b;
          tgad_pkg::HB_DEPTH:     pix_bytes_nxt = {16'd0, b};
          tgad_pkg::HB_DESC:      top_nxt = b[tgad_pkg::TOP_BIT];
          default: ;
        endcase
        if (!hdr_last) begin
          hdr_cnt_nxt = hdr_cnt_r + 5'd1;
          res_emit    = eof;
          res.status  = tgad_pkg::ST_SHORT_HDR;
        end else if (hdr_err != tgad_pkg::ST_PIXEL) begin
          res_emit   = 1'b1;
          res.status = hdr_err;
        end else begin
          four_nxt      = (pix_bytes_r[7:0] == tgad_pkg::DEPTH_32);
          pix_bytes_nxt = 24'd0;
          pix_idx_nxt   = 2'd0;
          res_emit      = eof;
        end
      end
      tgad_pkg::PH_IDSKIP: begin
        id_left_nxt = id_left_r - 8'd1;
        res_emit    = eof;
      end
      tgad_pkg::PH_PACKET: begin
        pkt_left_nxt = (b & tgad_pkg::COUNT_MASK) + 8'd1;
        pkt_run_nxt  = b[tgad_pkg::RUN_BIT];
        pix_idx_nxt  = 2'd0;
        res_emit     = eof;
      end
      tgad_pkg::PH_PIXEL: begin
        if (!pix_end) begin
          case (pix_idx_r)
            2'd0:    pix_bytes_nxt[7:0]   = b;
            2'd1:    pix_bytes_nxt[15:8]  = b;
            default: pix_bytes_nxt[23:16] = b;
          endcase
          pix_idx_nxt = pix_idx_r + 2'd1;
          res_emit    = eof;
        end else begin
          done_nxt    = done_r + {24'd0, rep_clip};
          pix_idx_nxt = 2'd0;
          if (rle_r) begin
            if (pkt_run_r || pkt_left_r <= 8'd1) begin
              pkt_left_nxt = 8'd0;
            end else begin
              pkt_left_nxt = pkt_left_r - 8'd1;
            end
          end
          res_emit         = 1'b1;
          res.blue         = pix_bytes_r[7:0];
          res.green        = pix_bytes_r[15:8];
          res.red          = four_r ? pix_bytes_r[23:16] : b;
          res.alpha        = four_r ? b : tgad_pkg::OPAQUE;
          res.repeat_count = rep_clip;
          // truncation wins only when the image is not complete
          res.status       = (!img_done && eof) ? tgad_pkg::ST_TRUNCATED :
                                                  tgad_pkg::ST_PIXEL;
          res.last         = img_done || eof;
        end
      end
      default: ;
    endcase

    res.top_origin   = top_nxt;
    res.image_width  = width_nxt;
    res.image_height = height_nxt;

    if (!in_fire) begin
      res_emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && eof)) begin
      phase_r     <= tgad_pkg::PH_HEADER;
      hdr_cnt_r   <= 5'd0;
      id_left_r   <= 8'd0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      four_r      <= 1'b0;
      rle_r       <= 1'b0;
      top_r       <= 1'b0;
      done_r      <= 32'd0;
      pkt_left_r  <= 8'd0;
      pkt_run_r   <= 1'b0;
      pix_bytes_r <= 24'd0;
      pix_idx_r   <= 2'd0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      id_left_r   <= id_left_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      four_r      <= four_nxt;
      rle_r       <= rle_nxt;
      top_r       <= top_nxt;
      done_r      <= done_nxt;
      pkt_left_r  <= pkt_left_nxt;
      pkt_run_r   <= pkt_run_nxt;
      pix_bytes_r <= pix_bytes_nxt;
      pix_idx_r   <= pix_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= width_r * height_r;
  end

  tgad_res_buf u_res_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_emit),
    .push_data  (res),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_word)
  );

  assign out_red          = out_word.red;
  assign out_green        = out_word.green;
  assign out_blue         = out_word.blue;
  assign out_alpha        = out_word.alpha;
  assign out_pixel_index  = out_word.pixel_index;
  assign out_repeat_count = out_word.repeat_count;
  assign out_status       = out_word.status;
  assign out_top_origin   = out_word.top_origin;
  assign out_image_width  = out_word.image_width;
  assign out_image_height = out_word.image_height;
  assign out_last         = out_word.last;

endmodule

[hw/rtl/tgad_checker.sv]
module tgad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_index,
  input logic [7:0]  out_repeat_count,
  input logic [2:0]  out_status,
  input logic        out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index))
    else $error("stalled result word changed");

  // any status word closes the image
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tgad_pkg::ST_PIXEL |-> out_last)
    else $error("status word without last");

  // a pixel word always covers at least one pixel
  a_pixel_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tgad_pkg::ST_PIXEL |-> out_repeat_count != 8'd0)
    else $error("pixel word with zero repeat count");

  // header errors come before any pixel is delivered
  a_hdr_err_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tgad_pkg::ST_SHORT_HDR ||
                  out_status == tgad_pkg::ST_ZERO_DIM ||
                  out_status == tgad_pkg::ST_BAD_DEPTH)
    |-> out_pixel_index == 32'd0 && out_repeat_count == 8'd0)
    else $error("header error word with pixel data");

  // empty result buffer never back-pressures the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result buffer");

endmodule

bind tga_rle_pixel_decoder tgad_checker u_tgad_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pixel_index  (out_pixel_index),
  .out_repeat_count (out_repeat_count),
  .out_status       (out_status),
  .out_last         (out_last)
);
